@@ design/pf_pkg.sv @@
// shared widths and divider control types for the prime factorizer
package pf_pkg;

    localparam int unsigned NUM_W  = 32;
    localparam int unsigned EXP_W  = 5;
    localparam int unsigned CAND_W = 17;
    localparam int unsigned SQ_W   = 33;

    localparam logic [CAND_W-1:0] FIRST_CAND = CAND_W'(2);
    localparam logic [SQ_W-1:0]   FIRST_SQ   = SQ_W'(4);

    typedef struct packed {
        logic              start;
        logic [NUM_W-1:0]  dividend;
        logic [CAND_W-1:0] divisor;
    } pf_div_req_t;

    typedef struct packed {
        logic              done;
        logic [NUM_W-1:0]  quotient;
        logic [CAND_W-1:0] rem;
    } pf_div_rsp_t;

endpackage

@@ design/pf_in_if.sv @@
// input channel carrying the number to factor
interface pf_in_if;
    logic                     valid;
    logic                     ready;
    logic [pf_pkg::NUM_W-1:0] number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

@@ design/pf_out_if.sv @@
// output channel carrying one prime factor result
interface pf_out_if;
    logic                     valid;
    logic                     ready;
    logic [pf_pkg::NUM_W-1:0] prime;
    logic [pf_pkg::EXP_W-1:0] exponent;
    logic                     last;
    logic                     empty_res;

    modport source (output valid, output prime, output exponent, output last,
                    output empty_res, input ready);
    modport sink   (input valid, input prime, input exponent, input last,
                    input empty_res, output ready);
endinterface

@@ design/prime_factorizer.sv @@
// top level: trial-division prime factorization of a 32-bit number
// a number below 2 gives its single empty result through the emit state and the output register
// otherwise each candidate costs a compare and then a division, repeated while it divides
// worst case (a prime near 2^32) is about 65535 candidates
// the bit-serial divider sets the pace; one number is worked at a time
// rst_n clears the sequencer and the result valid flag asynchronously
module prime_factorizer #(
    parameter int unsigned MAX_PRIMES = 12
) (
    input  logic     clk,
    input  logic     rst_n,
    pf_in_if.sink    operand,
    pf_out_if.source result
);
    import pf_pkg::*;

    localparam int unsigned FOUND_W = $clog2(MAX_PRIMES + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_EMIT
    } state_t;

    state_t            state_reg;

    // working registers of the trial loop
    logic [NUM_W-1:0]   rem_reg;
    logic [CAND_W-1:0]  cand_reg;
    logic [SQ_W-1:0]    sq_reg;      // cand_reg squared, kept by adding 2c+1
    logic [EXP_W-1:0]   mult_reg;
    logic [FOUND_W-1:0] found_reg;
    logic               start_reg;

    // result waiting to be loaded into the output register
    logic [NUM_W-1:0]   pend_prime_reg;
    logic [EXP_W-1:0]   pend_exp_reg;
    logic               pend_last_reg;
    logic               pend_empty_reg;

    // output register
    logic               out_valid_reg;
    logic [NUM_W-1:0]   out_prime_reg;
    logic [EXP_W-1:0]   out_exp_reg;
    logic               out_last_reg;
    logic               out_empty_reg;

    pf_div_req_t        div_req;
    pf_div_rsp_t        div_rsp;

    logic [SQ_W-1:0]    sq_next;
    logic               limit_hit;

    assign div_req.start    = start_reg;
    assign div_req.dividend = rem_reg;
    assign div_req.divisor  = cand_reg;

    pf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // (c+1)^2 = c^2 + 2c + 1
    assign sq_next   = SQ_W'(sq_reg + {cand_reg, 1'b1});
    // this prime is the last one allowed
    assign limit_hit = (FOUND_W'(found_reg + 1'b1) == FOUND_W'(MAX_PRIMES));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            start_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            rem_reg        <= '0;
            cand_reg       <= '0;
            sq_reg         <= '0;
            mult_reg       <= '0;
            found_reg      <= '0;
            pend_prime_reg <= '0;
            pend_exp_reg   <= '0;
            pend_last_reg  <= 1'b0;
            pend_empty_reg <= 1'b0;
            out_prime_reg  <= '0;
            out_exp_reg    <= '0;
            out_last_reg   <= 1'b0;
            out_empty_reg  <= 1'b0;
        end
        else
        begin
            // S_EMIT drives the output register itself
            if (result.ready && state_reg != S_EMIT)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (operand.valid)
                    begin
                        rem_reg   <= operand.number;
                        cand_reg  <= FIRST_CAND;
                        sq_reg    <= FIRST_SQ;
                        mult_reg  <= '0;
                        found_reg <= '0;
                        if (operand.number[NUM_W-1:1] == '0)
                        begin
                            // zero or one: single empty result
                            pend_prime_reg <= '0;
                            pend_exp_reg   <= '0;
                            pend_last_reg  <= 1'b1;
                            pend_empty_reg <= 1'b1;
                            state_reg      <= S_EMIT;
                        end
                        else
                        begin
                            state_reg <= S_CHECK;
                        end
                    end
                end

                S_CHECK:
                begin
                    if (sq_reg > {1'b0, rem_reg})
                    begin
                        // nothing up to the square root divides: remainder is prime
                        pend_prime_reg <= rem_reg;
                        pend_exp_reg   <= EXP_W'(1);
                        pend_last_reg  <= 1'b1;
                        pend_empty_reg <= 1'b0;
                        state_reg      <= S_EMIT;
                    end
                    else
                    begin
                        start_reg <= 1'b1;
                        state_reg <= S_DIV;
                    end
                end

                S_DIV:
                begin
                    // a start pulse lasts one cycle; it repeats while the candidate divides
                    start_reg <= div_rsp.done && (div_rsp.rem == '0);
                    if (div_rsp.done)
                    begin
                        if (div_rsp.rem == '0)
                        begin
                            // divides again: take it out and retry the same candidate
                            rem_reg   <= div_rsp.quotient;
                            mult_reg  <= mult_reg + 1'b1;
                        end
                        else if (mult_reg != '0)
                        begin
                            pend_prime_reg <= NUM_W'(cand_reg);
                            pend_exp_reg   <= mult_reg;
                            pend_last_reg  <= (rem_reg == NUM_W'(1)) || limit_hit;
                            pend_empty_reg <= 1'b0;
                            found_reg      <= FOUND_W'(found_reg + 1'b1);
                            state_reg      <= S_EMIT;
                        end
                        else
                        begin
                            cand_reg  <= cand_reg + 1'b1;
                            sq_reg    <= sq_next;
                            state_reg <= S_CHECK;
                        end
                    end
                end

                S_EMIT:
                begin
                    // wait for the output register to be free
                    if (!out_valid_reg || result.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_prime_reg <= pend_prime_reg;
                        out_exp_reg   <= pend_exp_reg;
                        out_last_reg  <= pend_last_reg;
                        out_empty_reg <= pend_empty_reg;
                        if (pend_last_reg)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            cand_reg  <= cand_reg + 1'b1;
                            sq_reg    <= sq_next;
                            mult_reg  <= '0;
                            state_reg <= S_CHECK;
                        end
                    end
                end

                default:
                begin
                    start_reg <= 1'b0;
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // a new number is taken only between numbers; a waiting result does not block it
    assign operand.ready    = (state_reg == S_IDLE);

    assign result.valid     = out_valid_reg;
    assign result.prime     = out_prime_reg;
    assign result.exponent  = out_exp_reg;
    assign result.last      = out_last_reg;
    assign result.empty_res = out_empty_reg;

endmodule

@@ design/pf_div.sv @@
// restoring divider, one quotient bit per cycle
module pf_div (
    input  logic                clk,
    input  logic                rst_n,
    input  pf_pkg::pf_div_req_t req,
    output pf_pkg::pf_div_rsp_t rsp
);
    import pf_pkg::*;

    localparam int unsigned CNT_W = $clog2(NUM_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic [CAND_W-1:0] part_reg;
    logic [CAND_W-1:0] dvs_reg;

    logic [CAND_W:0]   trial;
    logic              fits;
    logic [CAND_W-1:0] part_next;
    logic [NUM_W-1:0]  quo_next;

    always_comb
    begin
        trial     = {part_reg, quo_reg[NUM_W-1]};
        fits      = (trial >= {1'b0, dvs_reg});
        part_next = fits ? CAND_W'(trial - {1'b0, dvs_reg}) : trial[CAND_W-1:0];
        quo_next  = {quo_reg[NUM_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (!busy_reg)
            begin
                if (req.start)
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= '0;
                end
            end
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!busy_reg && req.start)
        begin
            quo_reg  <= req.dividend;
            dvs_reg  <= req.divisor;
            part_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg  <= quo_next;
            part_reg <= part_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;
    assign rsp.rem      = part_reg;

endmodule

@@ design/pf_checker.sv @@
// port-level checks for the prime factorizer and their binding
module pf_checker (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic [pf_pkg::NUM_W-1:0] prime,
    input logic [pf_pkg::EXP_W-1:0] exponent,
    input logic                     last,
    input logic                     empty_res
);
    import pf_pkg::*;

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // the empty result is a final result with zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && empty_res |-> last && prime == '0 && exponent == '0)
        else $error("empty result malformed");

    // a real factor is at least 2 and occurs at least once
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !empty_res |-> prime[NUM_W-1:1] != '0 && exponent != '0)
        else $error("factor result malformed");

    // a factor result with an exponent above one is a prime below 2^16
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !empty_res && exponent[EXP_W-1:1] != '0
        |-> prime[NUM_W-1:CAND_W-1] == '0)
        else $error("repeated factor too large");

endmodule

bind prime_factorizer pf_checker u_pf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .prime     (result.prime),
    .exponent  (result.exponent),
    .last      (result.last),
    .empty_res (result.empty_res)
);

@@ tb/tb.sv @@
// testbench for prime_factorizer: directed and random numbers, factor results checked in order
module tb;

    import pf_pkg::*;

    // the block is built with the same prime limit that the predictor uses
    localparam int unsigned PRIME_LIMIT    = 12;
    // a 32-bit number never has more than nine distinct primes
    localparam int unsigned MAX_FACTORS    = 9;
    // receiver hold-off long enough to fill the block and stall its input
    localparam int unsigned HOLD_CYCLES    = 3000;
    // slowest directed number (a prime near one million) needs about 1000
    // candidates, each a compare and a division
    localparam int unsigned WATCHDOG_LIMIT = 200000;
    // a number below 2 answers straight from the emit state; allow for stray results
    localparam int unsigned TAIL_CYCLES    = 50;
    localparam int unsigned PRINT_LIMIT    = 40;

    // one expected result: a prime with its exponent and the two flags
    typedef struct packed {
        logic [NUM_W-1:0] prime;
        logic [EXP_W-1:0] exponent;
        logic             last;
        logic             empty_res;
    } factor_t;

    logic clk;
    logic rst_n;

    pf_in_if  operand_ch ();
    pf_out_if result_ch ();

    prime_factorizer #(
        .MAX_PRIMES(PRIME_LIMIT)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .operand(operand_ch),
        .result (result_ch)
    );

    // factors still owed by the block, oldest first
    factor_t     pending_factors[$];
    int unsigned mismatch_count;
    int unsigned quiet_cycles;

    // idle rates in percent of cycles for each side
    int unsigned sender_idle_pct;
    int unsigned receiver_idle_pct;

    // long receiver hold-off: requested by a test, counted down by the receiver
    bit          hold_req;
    int unsigned hold_left;

    // 100 MHz style clock, period 10
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit roll(input int unsigned pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // one line per mismatch, with printing capped so a broken block stays readable
    task automatic report_mismatch(input string what, input logic [NUM_W-1:0] got,
                                   input logic [NUM_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("%0t: %s got %0d, want %0d", $time, what, got, want);
    endtask

    // trial division in the same order as the block: candidates 2, 3, 4 and on,
    // stopping once candidate squared passes what is left, which is then prime
    task automatic predict_factors(input logic [NUM_W-1:0] value);
        logic [NUM_W-1:0] rest;
        logic [NUM_W-1:0] cand;
        logic [EXP_W-1:0] mult;
        int unsigned      found;
        factor_t          held;
        bit               have_held;
        rest      = value;
        cand      = NUM_W'(2);
        found     = 0;
        have_held = 1'b0;
        held      = '0;
        // zero and one have no factors: a single empty result
        if (value < NUM_W'(2))
        begin
            held.last      = 1'b1;
            held.empty_res = 1'b1;
            pending_factors.push_back(held);
            return;
        end
        while (rest != NUM_W'(1) && found < PRIME_LIMIT && found < MAX_FACTORS)
        begin
            if ((64'(cand) * 64'(cand)) > 64'(rest))
            begin
                // what is left is itself a prime
                if (have_held)
                    pending_factors.push_back(held);
                held      = '{prime: rest, exponent: EXP_W'(1), last: 1'b0, empty_res: 1'b0};
                have_held = 1'b1;
                found++;
                break;
            end
            if ((rest % cand) == '0)
            begin
                mult = '0;
                while ((rest % cand) == '0)
                begin
                    rest = rest / cand;
                    mult = mult + EXP_W'(1);
                end
                if (have_held)
                    pending_factors.push_back(held);
                held      = '{prime: cand, exponent: mult, last: 1'b0, empty_res: 1'b0};
                have_held = 1'b1;
                found++;
            end
            cand = cand + NUM_W'(1);
        end
        // the final factor of a number carries last
        held.last = 1'b1;
        pending_factors.push_back(held);
    endtask

    // offer one number, with a random gap first, and wait for its transfer;
    // valid is left high after the transfer
    task automatic send_number(input logic [NUM_W-1:0] value);
        while (roll(sender_idle_pct))
        begin
            operand_ch.valid <= 1'b0;
            @(posedge clk);
        end
        operand_ch.valid  <= 1'b1;
        operand_ch.number <= value;
        @(posedge clk);
        while (!operand_ch.ready)
            @(posedge clk);
        predict_factors(value);
    endtask

    // stop offering and wait until every owed factor has come out
    task automatic wait_results_drained();
        operand_ch.valid <= 1'b0;
        while (pending_factors.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
        sender_idle_pct   = send_pct;
        receiver_idle_pct = recv_pct;
    endtask

    // numbers built from small factors and one cofactor of at most 20000, so that
    // trial division ends within about 150 candidates while the value still
    // reaches into the upper bits
    function automatic logic [NUM_W-1:0] smooth_number();
        logic [63:0] acc;
        int unsigned k;
        if ($urandom_range(0, 9) == 0)
            return NUM_W'($urandom_range(0, 3));
        acc = roll(50) ? 64'($urandom_range(2, 20000)) : 64'd1;
        repeat (40)
        begin
            k = roll(25) ? $urandom_range(2, 3) : $urandom_range(2, 64);
            if (acc * k > 64'hFFFF_FFFF)
                break;
            acc = acc * k;
            if (roll(8))
                break;
        end
        return acc[NUM_W-1:0];
    endfunction

    // receiver: random stalls, or a counted hold-off when a test asks for one
    always @(posedge clk)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else if (hold_left != 0)
        begin
            result_ch.ready <= 1'b0;
            hold_left       <= hold_left - 1;
        end
        else if (hold_req)
        begin
            result_ch.ready <= 1'b0;
            hold_req        <= 1'b0;
            hold_left       <= HOLD_CYCLES - 1;
        end
        else
            result_ch.ready <= !roll(receiver_idle_pct);
    end

    // result checker: every transfer out is matched against the oldest owed factor
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_factors.size() == 0)
                report_mismatch("unexpected result, prime", result_ch.prime, '0);
            else
            begin
                if (result_ch.prime !== pending_factors[0].prime)
                    report_mismatch("prime", result_ch.prime, pending_factors[0].prime);
                if (result_ch.exponent !== pending_factors[0].exponent)
                    report_mismatch("exponent", NUM_W'(result_ch.exponent),
                                    NUM_W'(pending_factors[0].exponent));
                if (result_ch.last !== pending_factors[0].last)
                    report_mismatch("last", NUM_W'(result_ch.last),
                                    NUM_W'(pending_factors[0].last));
                if (result_ch.empty_res !== pending_factors[0].empty_res)
                    report_mismatch("empty_res", NUM_W'(result_ch.empty_res),
                                    NUM_W'(pending_factors[0].empty_res));
                void'(pending_factors.pop_front());
            end
        end
    end

    // watchdog: too long without any transfer on either side ends the run
    always @(posedge clk)
    begin
        if ((operand_ch.valid && operand_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", quiet_cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    // extremes of the field and the special cases: empty results, the largest
    // exponent, nine distinct primes, a square of the smallest factor pair and
    // remainders that end as a prime
    task automatic test_boundary_numbers();
        logic [NUM_W-1:0] numbers[$];
        numbers = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'hFFFF_FFFF, 32'h8000_0000,
                    32'd3486784401, 32'd223092870, 32'd446185740, 32'd4238764530,
                    32'd64507, 32'd65537, 32'd4294836225, 32'd25, 32'd49, 32'd97,
                    32'd65535, 32'd3221225472, 32'd1000003, 32'd6};
        set_idling(28, 53);
        foreach (numbers[i])
            send_number(numbers[i]);
    endtask

    // hold the receiver off while numbers keep coming, then pause until drained
    task automatic test_backpressure_fill();
        set_idling(0, 0);
        hold_req <= 1'b1;
        repeat (6)
            send_number(smooth_number());
        wait_results_drained();
    endtask

    // random smooth numbers under each idling mix, ending with no idling
    task automatic test_random_smooth_numbers();
        set_idling(28, 53);
        repeat (25)
            send_number(smooth_number());
        set_idling(53, 28);
        repeat (25)
            send_number(smooth_number());
        set_idling(0, 0);
        repeat (23)
            send_number(smooth_number());
    endtask

    initial
    begin
        // every block input known from time zero
        rst_n             = 1'b0;
        operand_ch.valid  = 1'b0;
        operand_ch.number = '0;
        result_ch.ready   = 1'b0;
        hold_req          = 1'b0;
        hold_left         = 0;
        mismatch_count    = 0;
        quiet_cycles      = 0;
        set_idling(0, 0);

        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;

        test_boundary_numbers();
        test_backpressure_fill();
        test_random_smooth_numbers();

        // let the last factors out, then watch a while for anything extra
        wait_results_drained();
        repeat (TAIL_CYCLES)
            @(posedge clk);

        if (mismatch_count == 0 && pending_factors.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ sim.f @@
design/pf_pkg.sv
design/pf_in_if.sv
design/pf_out_if.sv
design/pf_div.sv
design/prime_factorizer.sv
design/pf_checker.sv
tb/tb.sv
